// ----- design/hmof_pkg.sv -----
// Package for the histogram mode outlier filter.
// Holds the queue entry type, the configuration register indexes and fixed sizes.
// No dependencies.
package hmof_pkg;

    localparam int VAL_W    = 32;
    localparam int QDEPTH   = 4;
    localparam int QPTR_W   = 2;
    localparam int QCNT_W   = 3;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_BIN_COUNT   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RANGE_FLOOR = 2'd1;

    localparam logic [6:0]  BIN_COUNT_RST   = 7'd8;
    localparam logic [15:0] RANGE_FLOOR_RST = 16'd66;

    localparam logic signed [VAL_W-1:0] VAL_MOST_POS = 32'sh7FFF_FFFF;
    localparam logic signed [VAL_W-1:0] VAL_MOST_NEG = 32'sh8000_0000;

    // One classified word from the front end.
    typedef struct packed {
        logic signed [VAL_W-1:0] value;
        logic                    valid;
        logic                    last;
        logic                    store;
        logic                    drop;
    } t_qent;

endpackage

// ----- design/hmof_front.sv -----
// Front end: accepts input words, counts them against capacity, classifies.
// Uses hmof_pkg.
module hmof_front #(
    parameter int MAX_ITEMS = 64
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic signed [31:0]          i_value,
    input  logic                        i_valid_req,
    input  logic                        i_last,
    input  logic                        i_q_full,
    output logic                        o_push,
    output hmof_pkg::t_qent             o_entry
);
    localparam int CNW = $clog2(MAX_ITEMS + 1);

    logic [CNW-1:0] r_fcnt, n_fcnt;
    logic           r_drop, n_drop;
    logic           w_acc, w_store;

    assign o_ready = !i_q_full;
    assign w_acc   = i_valid && !i_q_full;
    assign w_store = r_fcnt < CNW'(MAX_ITEMS);

    // Dropped words that do not close a set never reach the queue.
    assign o_push        = w_acc && (w_store || i_last);
    assign o_entry.value = i_value;
    assign o_entry.valid = i_valid_req;
    assign o_entry.last  = i_last;
    assign o_entry.store = w_store;
    assign o_entry.drop  = r_drop || !w_store;

    always_comb begin
        n_fcnt = r_fcnt;
        n_drop = r_drop;
        if (w_acc) begin
            if (i_last) begin
                n_fcnt = '0;
                n_drop = 1'b0;
            end else if (w_store) begin
                n_fcnt = r_fcnt + 1'b1;
            end else begin
                n_drop = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fcnt <= '0;
            r_drop <= 1'b0;
        end else begin
            r_fcnt <= n_fcnt;
            r_drop <= n_drop;
        end
    end

endmodule

// ----- design/hmof_queue.sv -----
// Short queue between front and back end.
// Uses hmof_pkg.
module hmof_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  hmof_pkg::t_qent i_entry,
    output logic            o_full,
    input  logic            i_pop,
    output hmof_pkg::t_qent o_head,
    output logic            o_empty
);
    hmof_pkg::t_qent                  r_mem [hmof_pkg::QDEPTH];
    logic [hmof_pkg::QPTR_W-1:0]      r_wp, r_rp;
    logic [hmof_pkg::QCNT_W-1:0]      r_cnt;
    logic                             w_push, w_pop;

    assign o_full  = r_cnt == hmof_pkg::QCNT_W'(hmof_pkg::QDEPTH);
    assign o_empty = r_cnt == '0;
    assign o_head  = r_mem[r_rp];
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wp] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) r_wp <= r_wp + 1'b1;
            if (w_pop)  r_rp <= r_rp + 1'b1;
            r_cnt <= r_cnt + hmof_pkg::QCNT_W'(w_push) - hmof_pkg::QCNT_W'(w_pop);
        end
    end

endmodule

// ----- design/hmof_div.sv -----
// Bin index unit: (d * bins) / span by restoring division, one quotient bit a cycle.
// No package dependency.
module hmof_div #(
    parameter int QW = 7
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [31:0]   i_diff,
    input  logic [QW-1:0] i_bins,
    input  logic [31:0]   i_span,
    output logic          o_done,
    output logic [QW-1:0] o_quot
);
    localparam int RW = 32 + QW;
    localparam int KW = $clog2(QW + 1);

    logic [RW-1:0] r_rem, r_dv;
    logic [QW-1:0] r_q;
    logic [KW-1:0] r_k;
    logic          r_busy, r_done;
    logic          w_ge;

    assign w_ge   = r_rem >= r_dv;
    assign o_done = r_done;
    assign o_quot = r_q;

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= RW'(i_diff) * RW'(i_bins);
            r_dv  <= RW'(i_span) << (QW - 1);
            r_q   <= '0;
        end else if (r_busy) begin
            if (w_ge) r_rem <= r_rem - r_dv;
            r_q  <= {r_q[QW-2:0], w_ge};
            r_dv <= r_dv >> 1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_k    <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_k    <= KW'(QW);
            end else if (r_busy) begin
                r_k <= r_k - 1'b1;
                if (r_k == KW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

endmodule

// ----- design/hmof_back.sv -----
// Back end: stores the set, finds range, bins and counts, emits kept words.
// Uses hmof_pkg and hmof_div.
module hmof_back #(
    parameter int MAX_ITEMS = 64,
    parameter int MAX_BINS  = 64
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_q_empty,
    input  hmof_pkg::t_qent    i_head,
    output logic               o_pop,
    input  logic [6:0]         i_bin_count,
    input  logic [15:0]        i_range_floor,
    output logic               o_valid,
    input  logic               i_ready,
    output logic signed [31:0] o_kept_value,
    output logic               o_kept_valid,
    output logic               o_end_of_set,
    output logic               o_nothing_kept,
    output logic               o_overflowed
);
    localparam int IW  = $clog2(MAX_ITEMS);
    localparam int CNW = $clog2(MAX_ITEMS + 1);
    localparam int BW  = $clog2(MAX_BINS);
    localparam int NBW = $clog2(MAX_BINS + 1);

    localparam logic [3:0] ST_LOAD     = 4'd0;
    localparam logic [3:0] ST_DECIDE   = 4'd1;
    localparam logic [3:0] ST_NONE     = 4'd2;
    localparam logic [3:0] ST_ECHO_RD  = 4'd3;
    localparam logic [3:0] ST_ECHO_PUT = 4'd4;
    localparam logic [3:0] ST_BIN_RD   = 4'd5;
    localparam logic [3:0] ST_BIN_CHK  = 4'd6;
    localparam logic [3:0] ST_BIN_DIV  = 4'd7;
    localparam logic [3:0] ST_BIN_RDC  = 4'd8;
    localparam logic [3:0] ST_BIN_UPD  = 4'd9;
    localparam logic [3:0] ST_EM_RD    = 4'd10;
    localparam logic [3:0] ST_EM_CNT   = 4'd11;
    localparam logic [3:0] ST_EM_PUT   = 4'd12;
    localparam logic [3:0] ST_EM_FLUSH = 4'd13;

    // Stores: value with its flag, bin of each item, count of each bin.
    logic [32:0]    r_vmem [MAX_ITEMS];
    logic [BW-1:0]  r_bmem [MAX_ITEMS];
    logic [CNW-1:0] r_cmem [MAX_BINS];

    logic [3:0]               r_state;
    logic [CNW-1:0]           r_cnt, r_idx, r_peak;
    logic signed [31:0]       r_min, r_max;
    logic                     r_any, r_drop;
    logic [31:0]              r_span;
    logic [MAX_BINS-1:0]      r_cv;
    logic [BW-1:0]            r_bin, r_binq;
    logic [32:0]              r_mem_q;
    logic [CNW-1:0]           r_cnt_q;
    logic                     r_pend;
    logic signed [31:0]       r_pend_val;
    logic                     r_ov, r_okv, r_olast, r_onone;
    logic signed [31:0]       r_oval;
    logic                     r_oovf_hold;

    logic                     w_can_put, w_last_idx, w_echo, w_qual;
    logic [32:0]              w_spread;
    logic [31:0]              w_diff;
    logic [8:0]               w_bc9, w_bins9;
    logic [NBW-1:0]           w_bins, w_quot, w_binc;
    logic                     w_div_start, w_div_done;
    logic [CNW-1:0]           w_newc;
    logic [BW-1:0]            w_caddr;
    logic                     w_emit_ph;

    assign w_can_put  = !r_ov || i_ready;
    assign w_last_idx = r_idx == r_cnt - 1'b1;
    assign w_spread   = {r_max[31], r_max} - {r_min[31], r_min};
    assign w_echo     = (w_spread[31:0] == '0) || (w_spread[31:0] < {16'd0, i_range_floor});
    assign w_diff     = 32'({r_mem_q[31], r_mem_q[31:0]} - {r_min[31], r_min});
    assign w_qual     = r_mem_q[32] && (r_cnt_q >= r_peak);
    assign w_newc     = (r_cv[r_bin] ? r_cnt_q : '0) + 1'b1;
    assign w_emit_ph  = (r_state == ST_EM_RD) || (r_state == ST_EM_CNT) ||
                        (r_state == ST_EM_PUT);
    assign w_caddr    = w_emit_ph ? r_binq : r_bin;
    assign o_pop      = (r_state == ST_LOAD) && !i_q_empty;

    // Zero acts as one bin, anything above the bin store acts as its size.
    assign w_bc9   = {2'b00, i_bin_count};
    assign w_bins9 = (w_bc9 == 9'd0) ? 9'd1 :
                     (w_bc9 > 9'(MAX_BINS)) ? 9'(MAX_BINS) : w_bc9;
    assign w_bins  = NBW'(w_bins9);
    assign w_binc  = (w_quot >= w_bins) ? w_bins - 1'b1 : w_quot;

    assign w_div_start = (r_state == ST_BIN_CHK) && r_mem_q[32];

    hmof_div #(.QW(NBW)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_diff  (w_diff),
        .i_bins  (w_bins),
        .i_span  (r_span),
        .o_done  (w_div_done),
        .o_quot  (w_quot)
    );

    // Memory ports: registered reads every cycle, writes in their own phase.
    always_ff @(posedge i_clk) begin
        r_mem_q <= r_vmem[r_idx[IW-1:0]];
        r_binq  <= r_bmem[r_idx[IW-1:0]];
        r_cnt_q <= r_cmem[w_caddr];
        if (o_pop && i_head.store) begin
            r_vmem[r_cnt[IW-1:0]] <= {i_head.valid, i_head.value};
        end
        if ((r_state == ST_BIN_DIV) && w_div_done) begin
            r_bmem[r_idx[IW-1:0]] <= BW'(w_binc);
        end
        if (r_state == ST_BIN_UPD) begin
            r_cmem[r_bin] <= w_newc;
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == ST_BIN_DIV) && w_div_done) r_bin <= BW'(w_binc);
        if (r_state == ST_DECIDE) r_span <= w_spread[31:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_LOAD;
            r_cnt   <= '0;
            r_idx   <= '0;
            r_peak  <= '0;
            r_min   <= hmof_pkg::VAL_MOST_POS;
            r_max   <= hmof_pkg::VAL_MOST_NEG;
            r_any   <= 1'b0;
            r_drop  <= 1'b0;
            r_cv    <= '0;
            r_pend  <= 1'b0;
            r_ov    <= 1'b0;
        end else begin
            if (i_ready) r_ov <= 1'b0;
            case (r_state)
                ST_LOAD: begin
                    if (o_pop) begin
                        if (i_head.store) begin
                            r_cnt <= r_cnt + 1'b1;
                            if (i_head.valid) begin
                                r_any <= 1'b1;
                                if (i_head.value < r_min) r_min <= i_head.value;
                                if (i_head.value > r_max) r_max <= i_head.value;
                            end
                        end
                        if (i_head.last) begin
                            r_drop  <= i_head.drop;
                            r_state <= ST_DECIDE;
                        end
                    end
                end
                ST_DECIDE: begin
                    r_idx <= '0;
                    if (!r_any) r_state <= ST_NONE;
                    else if (w_echo) r_state <= ST_ECHO_RD;
                    else r_state <= ST_BIN_RD;
                end
                ST_NONE: begin
                    if (w_can_put) begin
                        r_ov    <= 1'b1;
                        r_oval  <= '0;
                        r_okv   <= 1'b0;
                        r_olast <= 1'b1;
                        r_onone <= 1'b1;
                        r_state <= ST_LOAD;
                    end
                end
                ST_ECHO_RD: r_state <= ST_ECHO_PUT;
                ST_ECHO_PUT: begin
                    if (w_can_put) begin
                        r_ov    <= 1'b1;
                        r_oval  <= r_mem_q[31:0];
                        r_okv   <= r_mem_q[32];
                        r_olast <= w_last_idx;
                        r_onone <= 1'b0;
                        r_idx   <= r_idx + 1'b1;
                        r_state <= w_last_idx ? ST_LOAD : ST_ECHO_RD;
                    end
                end
                ST_BIN_RD: r_state <= ST_BIN_CHK;
                ST_BIN_CHK: begin
                    if (r_mem_q[32]) begin
                        r_state <= ST_BIN_DIV;
                    end else if (w_last_idx) begin
                        r_idx   <= '0;
                        r_state <= ST_EM_RD;
                    end else begin
                        r_idx   <= r_idx + 1'b1;
                        r_state <= ST_BIN_RD;
                    end
                end
                ST_BIN_DIV: begin
                    if (w_div_done) r_state <= ST_BIN_RDC;
                end
                ST_BIN_RDC: r_state <= ST_BIN_UPD;
                ST_BIN_UPD: begin
                    r_cv[r_bin] <= 1'b1;
                    if (w_newc > r_peak) r_peak <= w_newc;
                    if (w_last_idx) begin
                        r_idx   <= '0;
                        r_state <= ST_EM_RD;
                    end else begin
                        r_idx   <= r_idx + 1'b1;
                        r_state <= ST_BIN_RD;
                    end
                end
                ST_EM_RD:  r_state <= ST_EM_CNT;
                ST_EM_CNT: r_state <= ST_EM_PUT;
                ST_EM_PUT: begin
                    // Hold each kept word back one step so the final one can carry tlast.
                    if (!w_qual || !r_pend || w_can_put) begin
                        if (w_qual) begin
                            if (r_pend) begin
                                r_ov    <= 1'b1;
                                r_oval  <= r_pend_val;
                                r_okv   <= 1'b1;
                                r_olast <= 1'b0;
                                r_onone <= 1'b0;
                            end
                            r_pend     <= 1'b1;
                            r_pend_val <= r_mem_q[31:0];
                        end
                        if (w_last_idx) begin
                            r_state <= ST_EM_FLUSH;
                        end else begin
                            r_idx   <= r_idx + 1'b1;
                            r_state <= ST_EM_RD;
                        end
                    end
                end
                ST_EM_FLUSH: begin
                    if (w_can_put) begin
                        r_ov    <= 1'b1;
                        r_oval  <= r_pend_val;
                        r_okv   <= 1'b1;
                        r_olast <= 1'b1;
                        r_onone <= 1'b0;
                        r_pend  <= 1'b0;
                        r_state <= ST_LOAD;
                    end
                end
                default: r_state <= ST_LOAD;
            endcase
            // Clear the set once its final word is placed.
            if (((r_state == ST_NONE) || (r_state == ST_EM_FLUSH) ||
                 ((r_state == ST_ECHO_PUT) && w_last_idx)) && w_can_put) begin
                r_cnt  <= '0;
                r_idx  <= '0;
                r_peak <= '0;
                r_min  <= hmof_pkg::VAL_MOST_POS;
                r_max  <= hmof_pkg::VAL_MOST_NEG;
                r_any  <= 1'b0;
                r_cv   <= '0;
            end
        end
    end

    // Overflow flag stays with the set being emitted.
    always_ff @(posedge i_clk) begin
        if (w_can_put) r_oovf_hold <= r_drop;
    end

    assign o_valid        = r_ov;
    assign o_kept_value   = r_oval;
    assign o_kept_valid   = r_okv;
    assign o_end_of_set   = r_olast;
    assign o_nothing_kept = r_onone;
    assign o_overflowed   = r_oovf_hold;

`ifndef SYNTHESIS
    a_cnt_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNW'(MAX_ITEMS))
        else $error("stored item count above capacity");
    a_peak_le_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_peak <= r_cnt)
        else $error("peak bin count above item count");
    a_div_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_done |-> (r_state == ST_BIN_DIV))
        else $error("divider finished outside the binning step");
    a_pop_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |-> (r_state == ST_LOAD))
        else $error("queue popped outside load phase");
`endif

endmodule

// ----- design/histogram_mode_outlier_filter_unit.sv -----
// Histogram mode outlier filter, top level.
// Instantiates hmof_front, hmof_queue and hmof_back; uses hmof_pkg.
//
// Input stream: one word per sample, tdata = value (Q16.16), tuser[0] = valid_req,
// tlast closes the set. Output stream: tdata = kept_value, tuser = kept_valid,
// nothing_kept, overflowed (lowest bit first), tlast = end_of_set.
// Configuration channel: index 0 = bin_count, index 1 = range_floor, taken any
// cycle; write only while no set is in flight.
// Load takes one word per cycle, while the four-entry queue has room; words
// past MAX_ITEMS are dropped and flag the set. After tlast the back end walks
// the stored set: range check, then per valid item a read, a check, a bin
// division in the restoring divider, a count read and a count update (only
// the read and check for an invalid item), then an emit pass with a read, a
// count read and a put per item; the divider dominates. Echoed sets take a
// read and a put per item.
// Reset empties the queue and the set and loads default registers. A stalled
// output holds its word; the back end waits and the queue fills, after which
// tready drops.
module histogram_mode_outlier_filter_unit #(
    parameter int MAX_ITEMS = 64,
    parameter int MAX_BINS  = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [31:0] i_s_tdata,   // [31:0] value
    input  logic [0:0]  i_s_tuser,   // [0] valid_req
    input  logic        i_s_tlast,
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [31:0] o_m_tdata,   // [31:0] kept_value
    output logic [2:0]  o_m_tuser,   // [0] kept_valid, [1] nothing_kept, [2] overflowed
    output logic        o_m_tlast,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [hmof_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [15:0] i_cfg_data
);
    logic [6:0]      r_bin_count;
    logic [15:0]     r_range_floor;
    logic            w_push, w_full, w_pop, w_empty;
    hmof_pkg::t_qent w_entry, w_head;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bin_count   <= hmof_pkg::BIN_COUNT_RST;
            r_range_floor <= hmof_pkg::RANGE_FLOOR_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                hmof_pkg::CFG_BIN_COUNT:   r_bin_count   <= i_cfg_data[6:0];
                hmof_pkg::CFG_RANGE_FLOOR: r_range_floor <= i_cfg_data;
                default: ;
            endcase
        end
    end

    hmof_front #(.MAX_ITEMS(MAX_ITEMS)) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_s_tvalid),
        .o_ready     (o_s_tready),
        .i_value     (i_s_tdata),
        .i_valid_req (i_s_tuser[0]),
        .i_last      (i_s_tlast),
        .i_q_full    (w_full),
        .o_push      (w_push),
        .o_entry     (w_entry)
    );

    hmof_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_entry (w_entry),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_head  (w_head),
        .o_empty (w_empty)
    );

    hmof_back #(.MAX_ITEMS(MAX_ITEMS), .MAX_BINS(MAX_BINS)) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_q_empty      (w_empty),
        .i_head         (w_head),
        .o_pop          (w_pop),
        .i_bin_count    (r_bin_count),
        .i_range_floor  (r_range_floor),
        .o_valid        (o_m_tvalid),
        .i_ready        (i_m_tready),
        .o_kept_value   (o_m_tdata),
        .o_kept_valid   (o_m_tuser[0]),
        .o_end_of_set   (o_m_tlast),
        .o_nothing_kept (o_m_tuser[1]),
        .o_overflowed   (o_m_tuser[2])
    );

endmodule
